// ----- hdl/bdsc_pkg.sv -----
// Shared types, constants and register codes for the box downscaler.
package bdsc_pkg;

  // Default sizing of the accumulator memory and the kernel
  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned MAX_SCALE_DEF = 16;

  // Fixed geometry of the source image and word layout
  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned CH_W         = 8;
  localparam int unsigned PIX_W        = 32;
  localparam int unsigned QUOT_STEPS   = 8;

  // Configuration port geometry
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned SCALE_W = 5;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned BADJ_W  = 9;

  // Register reset values
  localparam logic [SCALE_W-1:0]       SCALE_RST  = 5'd2;
  localparam logic [SIZE_W-1:0]        WIDTH_RST  = 13'd64;
  localparam logic [SIZE_W-1:0]        HEIGHT_RST = 13'd64;
  localparam logic signed [BADJ_W-1:0] BADJ_RST   = 9'sd0;

  // Register indexes (word address)
  typedef enum logic [2:0] {
    REG_SCALE   = 3'd0,
    REG_WIDTH   = 3'd1,
    REG_HEIGHT  = 3'd2,
    REG_BADJ    = 3'd3,
    REG_AWEIGHT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [SCALE_W-1:0]       scale;
    logic [SIZE_W-1:0]        img_w;
    logic [SIZE_W-1:0]        img_h;
    logic signed [BADJ_W-1:0] badj;
    logic                     skip_clear;
  } cfg_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_FIXC,
    ST_FIXR
  } state_e;

endpackage

// ----- hdl/box_downscale_2d_alpha_weighted.sv -----
// Box downscaler for an ARGB8888 raster stream, alpha-weighted averaging.
// Each accepted source word is followed by a read-modify-write of the column
// accumulator memory, whose read data is registered. The last word of a kernel
// block also waits for the bit-serial mean unit (eight quotient bits in turn,
// then the output load), plus any wait for the output register to drain. After
// any register write, the first source word offered makes the block re-derive
// its position inside the kernel grid with a bit-serial divider, for the column
// and then for the row, before that word can be taken. The accumulator memory
// holds MAX_WIDTH/2 entries and needs no clearing pass.
module box_downscale_2d_alpha_weighted #(
  parameter int unsigned MAX_WIDTH = bdsc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_SCALE = bdsc_pkg::MAX_SCALE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdsc_pkg::PADDR_W-1:0] paddr,
  input  logic [bdsc_pkg::PDATA_W-1:0] pwdata,
  output logic [bdsc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bdsc_pkg::PIX_W-1:0]   pixel_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bdsc_pkg::PIX_W-1:0]   pixel_out_o,
  output logic                         last_out_o
);

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W   = bdsc_pkg::ROW_W;
  localparam int unsigned DV_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned G_W     = DV_W + 3;
  localparam int unsigned DCNT_W  = $clog2(DV_W + 1);
  localparam int unsigned KX_W    = $clog2(MAX_SCALE + 1);
  localparam int unsigned IX_W    = $clog2(MAX_SCALE);
  localparam int unsigned DEPTH   = MAX_WIDTH / 2;
  localparam int unsigned SLOT_W  = $clog2(DEPTH);
  localparam int unsigned ACC_W   = $clog2(255 * MAX_SCALE * MAX_SCALE + 1);
  localparam int unsigned TALLY_W = $clog2(MAX_SCALE * MAX_SCALE + 1);
  localparam int unsigned MEM_W   = 4 * ACC_W + TALLY_W;
  localparam int unsigned CH_W    = bdsc_pkg::CH_W;

  bdsc_pkg::cfg_t   cfg;
  logic             cfg_wr;
  bdsc_pkg::state_e state_q, state_d;

  logic [COL_W-1:0]  col_q, col_d, bxs_q, bxs_d;
  logic [ROW_W-1:0]  row_q, row_d, bys_q, bys_d;
  logic [IX_W-1:0]   ix_q, ix_d, iy_q, iy_d;
  logic [SLOT_W-1:0] slot_q, slot_d, wslot_q, wslot_d;
  logic              dirty_q, dirty_d;
  logic [DV_W-1:0]   dvd_q, dvd_d, quo_q, quo_d;
  logic [KX_W-1:0]   rem_q, rem_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;

  logic [bdsc_pkg::PIX_W-1:0] px_q, px_d;
  logic first_q, first_d, bend_q, bend_d, inr_q, inr_d, limg_q, limg_d;

  logic                       out_valid_q, out_valid_d, last_q, last_d;
  logic [bdsc_pkg::PIX_W-1:0] pix_q, pix_d;

  // Register bank
  bdsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .wr_o    (cfg_wr)
  );

  // Effective geometry from the registers
  logic [G_W-1:0] sw_g, sh_g, sc_g, w_g, h_g, kx_g, ky_g;
  always_comb begin
    sw_g = G_W'(cfg.img_w);
    sh_g = G_W'(cfg.img_h);
    sc_g = G_W'(cfg.scale);
    if (sw_g == '0)                  w_g = G_W'(1);
    else if (sw_g > G_W'(MAX_WIDTH)) w_g = G_W'(MAX_WIDTH);
    else                             w_g = sw_g;
    if (sh_g == '0)                             h_g = G_W'(1);
    else if (sh_g > G_W'(bdsc_pkg::HEIGHT_LIMIT)) h_g = G_W'(bdsc_pkg::HEIGHT_LIMIT);
    else                                        h_g = sh_g;
    if (sc_g < G_W'(2))                   sc_g = G_W'(2);
    else if (sc_g > G_W'(MAX_SCALE))      sc_g = G_W'(MAX_SCALE);
    kx_g = (sc_g < w_g) ? sc_g : w_g;
    ky_g = (sc_g < h_g) ? sc_g : h_g;
  end

  // Position terms, widened for compare
  logic [G_W-1:0] col_g, row_g, ix_g, iy_g, bxs_g, bys_g;
  assign col_g = G_W'(col_q);
  assign row_g = G_W'(row_q);
  assign ix_g  = G_W'(ix_q);
  assign iy_g  = G_W'(iy_q);
  assign bxs_g = G_W'(bxs_q);
  assign bys_g = G_W'(bys_q);

  // Position normalisation after a register change, committed once re-derived
  logic [G_W-1:0]   row_t;
  logic             col_wrap;
  logic [COL_W-1:0] col_n;
  logic [ROW_W-1:0] row_n;
  assign col_wrap = col_g >= w_g;
  assign row_t    = col_wrap ? row_g + 1'b1 : row_g;
  assign col_n    = col_wrap ? '0 : col_q;
  assign row_n    = (row_t >= h_g) ? '0 : ROW_W'(row_t);

  // Bit-serial divider step for the position fix-up
  logic [KX_W-1:0] div_k;
  logic [KX_W:0]   trial;
  logic            dv_ge;
  logic [KX_W-1:0] rem_nx;
  logic [DV_W-1:0] quo_nx;
  assign div_k  = (state_q == bdsc_pkg::ST_FIXR) ? KX_W'(ky_g) : KX_W'(kx_g);
  assign trial  = {rem_q, dvd_q[DV_W-1]};
  assign dv_ge  = trial >= {1'b0, div_k};
  assign rem_nx = dv_ge ? KX_W'(trial - {1'b0, div_k}) : KX_W'(trial);
  assign quo_nx = {quo_q[DV_W-2:0], dv_ge};

  // Accumulator memory and read-modify-write data path
  logic                 mem_re, mem_we;
  logic [MEM_W-1:0]     mem_rd, mem_wd;
  logic                 counted;
  logic [CH_W-1:0]      c_a, c_r, c_g, c_b;
  logic [ACC_W-1:0]     s_a, s_r, s_g, s_b;
  logic [TALLY_W-1:0]   s_n;
  logic                 mean_start, mean_busy;
  logic [bdsc_pkg::PIX_W-1:0] mean_pix;

  bdsc_acc_mem #(
    .DEPTH (DEPTH),
    .W     (MEM_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wslot_q),
    .wdata_i (mem_wd),
    .re_i    (mem_re),
    .raddr_i (slot_q),
    .rdata_o (mem_rd)
  );

  always_comb begin
    counted = (px_q[31:24] != '0) || !cfg.skip_clear;
    c_a = counted ? px_q[31:24] : '0;
    c_r = counted ? px_q[23:16] : '0;
    c_g = counted ? px_q[15:8]  : '0;
    c_b = counted ? px_q[7:0]   : '0;
    if (first_q) begin
      s_a = ACC_W'(c_a);
      s_r = ACC_W'(c_r);
      s_g = ACC_W'(c_g);
      s_b = ACC_W'(c_b);
      s_n = TALLY_W'(counted);
    end else begin
      s_a = mem_rd[4*ACC_W+TALLY_W-1 -: ACC_W] + ACC_W'(c_a);
      s_r = mem_rd[3*ACC_W+TALLY_W-1 -: ACC_W] + ACC_W'(c_r);
      s_g = mem_rd[2*ACC_W+TALLY_W-1 -: ACC_W] + ACC_W'(c_g);
      s_b = mem_rd[ACC_W+TALLY_W-1 -: ACC_W]   + ACC_W'(c_b);
      s_n = mem_rd[TALLY_W-1:0] + TALLY_W'(counted);
    end
    mem_wd = {s_a, s_r, s_g, s_b, s_n};
  end

  bdsc_mean #(
    .ACC_W   (ACC_W),
    .TALLY_W (TALLY_W)
  ) u_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mean_start),
    .sum_a_i (s_a),
    .sum_r_i (s_r),
    .sum_g_i (s_g),
    .sum_b_i (s_b),
    .tally_i (s_n),
    .badj_i  (cfg.badj),
    .busy_o  (mean_busy),
    .pixel_o (mean_pix)
  );

  assign in_ready_o = (state_q == bdsc_pkg::ST_IDLE) && !dirty_q;

  // Sequencer: next state and control
  always_comb begin
    state_d = state_q;
    col_d = col_q;   row_d = row_q;
    ix_d = ix_q;     iy_d = iy_q;
    bxs_d = bxs_q;   bys_d = bys_q;
    slot_d = slot_q; wslot_d = wslot_q;
    dirty_d = dirty_q || cfg_wr;
    dvd_d = dvd_q;   rem_d = rem_q;  quo_d = quo_q;  dcnt_d = dcnt_q;
    px_d = px_q;     first_d = first_q; bend_d = bend_q;
    inr_d = inr_q;   limg_d = limg_q;
    mem_re = 1'b0;   mem_we = 1'b0;  mean_start = 1'b0;
    pix_d = pix_q;   last_d = last_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      bdsc_pkg::ST_IDLE: begin
        if (dirty_q) begin
          // re-derive the grid place once a word is offered and the registers settle
          if (in_valid_i && !cfg_wr) begin
            dvd_d  = DV_W'(col_n);
            rem_d  = '0;
            quo_d  = '0;
            dcnt_d = DCNT_W'(DV_W);
            state_d = bdsc_pkg::ST_FIXC;
          end
        end else if (in_valid_i) begin
          // capture word and its place in the grid
          px_d    = pixel_in_i;
          first_d = (ix_q == '0) && (iy_q == '0);
          bend_d  = (ix_g == kx_g - 1'b1) && (iy_g == ky_g - 1'b1);
          inr_d   = (bxs_g + kx_g <= w_g) && (bys_g + ky_g <= h_g);
          limg_d  = (bxs_g + (kx_g << 1) > w_g) && (bys_g + (ky_g << 1) > h_g);
          wslot_d = slot_q;
          mem_re  = 1'b1;
          // advance the position
          if (col_g + 1'b1 >= w_g) begin
            col_d = '0; ix_d = '0; bxs_d = '0; slot_d = '0;
            if (row_g + 1'b1 >= h_g) begin
              row_d = '0; iy_d = '0; bys_d = '0;
            end else begin
              row_d = row_q + 1'b1;
              if (iy_g == ky_g - 1'b1) begin
                iy_d  = '0;
                bys_d = ROW_W'(bys_g + ky_g);
              end else begin
                iy_d = iy_q + 1'b1;
              end
            end
          end else begin
            col_d = col_q + 1'b1;
            if (ix_g == kx_g - 1'b1) begin
              ix_d   = '0;
              bxs_d  = COL_W'(bxs_g + kx_g);
              slot_d = slot_q + 1'b1;
            end else begin
              ix_d = ix_q + 1'b1;
            end
          end
          state_d = bdsc_pkg::ST_UPD;
        end
      end
      bdsc_pkg::ST_UPD: begin
        mem_we = inr_q;
        if (inr_q && bend_q) begin
          mean_start = 1'b1;
          state_d    = bdsc_pkg::ST_DIV;
        end else begin
          state_d = bdsc_pkg::ST_IDLE;
        end
      end
      bdsc_pkg::ST_DIV: begin
        if (!mean_busy && (!out_valid_q || out_ready_i)) begin
          out_valid_d = 1'b1;
          pix_d       = mean_pix;
          last_d      = limg_q;
          state_d     = bdsc_pkg::ST_IDLE;
        end
      end
      bdsc_pkg::ST_FIXC: begin
        if (cfg_wr) begin
          // registers moved under the divider: start over
          state_d = bdsc_pkg::ST_IDLE;
        end else begin
          dvd_d  = dvd_q << 1;
          rem_d  = rem_nx;
          quo_d  = quo_nx;
          dcnt_d = dcnt_q - 1'b1;
          if (dcnt_q == DCNT_W'(1)) begin
            ix_d   = IX_W'(rem_nx);
            slot_d = SLOT_W'(quo_nx);
            bxs_d  = col_n - COL_W'(rem_nx);
            dvd_d  = DV_W'(row_n);
            rem_d  = '0;
            quo_d  = '0;
            dcnt_d = DCNT_W'(DV_W);
            state_d = bdsc_pkg::ST_FIXR;
          end
        end
      end
      bdsc_pkg::ST_FIXR: begin
        if (cfg_wr) begin
          state_d = bdsc_pkg::ST_IDLE;
        end else begin
          dvd_d  = dvd_q << 1;
          rem_d  = rem_nx;
          quo_d  = quo_nx;
          dcnt_d = dcnt_q - 1'b1;
          if (dcnt_q == DCNT_W'(1)) begin
            col_d   = col_n;
            row_d   = row_n;
            iy_d    = IX_W'(rem_nx);
            bys_d   = row_n - ROW_W'(rem_nx);
            dirty_d = 1'b0;
            state_d = bdsc_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = bdsc_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdsc_pkg::ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      ix_q        <= '0;
      iy_q        <= '0;
      bxs_q       <= '0;
      bys_q       <= '0;
      slot_q      <= '0;
      dirty_q     <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      ix_q        <= ix_d;
      iy_q        <= iy_d;
      bxs_q       <= bxs_d;
      bys_q       <= bys_d;
      slot_q      <= slot_d;
      dirty_q     <= dirty_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wslot_q <= wslot_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    px_q    <= px_d;
    first_q <= first_d;
    bend_q  <= bend_d;
    inr_q   <= inr_d;
    limg_q  <= limg_d;
    pix_q   <= pix_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pix_q;
  assign last_out_o  = last_q;

endmodule

// ----- hdl/bdsc_regs.sv -----
// APB-style configuration register bank of the box downscaler.
module bdsc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdsc_pkg::PADDR_W-1:0]  paddr,
  input  logic [bdsc_pkg::PDATA_W-1:0]  pwdata,
  output logic [bdsc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output bdsc_pkg::cfg_t                cfg_o,
  output logic                          wr_o
);

  bdsc_pkg::cfg_t   cfg_q, cfg_d;
  bdsc_pkg::reg_idx_e idx;
  logic             wr;

  assign idx    = bdsc_pkg::reg_idx_e'(paddr[bdsc_pkg::PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign wr_o   = wr;
  assign cfg_o  = cfg_q;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        bdsc_pkg::REG_SCALE:   cfg_d.scale      = pwdata[bdsc_pkg::SCALE_W-1:0];
        bdsc_pkg::REG_WIDTH:   cfg_d.img_w      = pwdata[bdsc_pkg::SIZE_W-1:0];
        bdsc_pkg::REG_HEIGHT:  cfg_d.img_h      = pwdata[bdsc_pkg::SIZE_W-1:0];
        bdsc_pkg::REG_BADJ:    cfg_d.badj       = $signed(pwdata[bdsc_pkg::BADJ_W-1:0]);
        bdsc_pkg::REG_AWEIGHT: cfg_d.skip_clear = pwdata[0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale      <= bdsc_pkg::SCALE_RST;
      cfg_q.img_w      <= bdsc_pkg::WIDTH_RST;
      cfg_q.img_h      <= bdsc_pkg::HEIGHT_RST;
      cfg_q.badj       <= bdsc_pkg::BADJ_RST;
      cfg_q.skip_clear <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      bdsc_pkg::REG_SCALE:   prdata = bdsc_pkg::PDATA_W'(cfg_q.scale);
      bdsc_pkg::REG_WIDTH:   prdata = bdsc_pkg::PDATA_W'(cfg_q.img_w);
      bdsc_pkg::REG_HEIGHT:  prdata = bdsc_pkg::PDATA_W'(cfg_q.img_h);
      bdsc_pkg::REG_BADJ:    prdata = bdsc_pkg::PDATA_W'($unsigned(cfg_q.badj));
      bdsc_pkg::REG_AWEIGHT: prdata = bdsc_pkg::PDATA_W'(cfg_q.skip_clear);
      default:               prdata = '0;
    endcase
  end

endmodule

// ----- hdl/bdsc_acc_mem.sv -----
// Column accumulator memory: one write port, one registered read port.
module bdsc_acc_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned W     = 73
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/bdsc_mean.sv -----
// Four-lane rounded mean: restoring divide, one quotient bit per cycle.
module bdsc_mean #(
  parameter int unsigned ACC_W   = 16,
  parameter int unsigned TALLY_W = 9
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ACC_W-1:0]                  sum_a_i,
  input  logic [ACC_W-1:0]                  sum_r_i,
  input  logic [ACC_W-1:0]                  sum_g_i,
  input  logic [ACC_W-1:0]                  sum_b_i,
  input  logic [TALLY_W-1:0]                tally_i,
  input  logic signed [bdsc_pkg::BADJ_W-1:0] badj_i,
  output logic                              busy_o,
  output logic [bdsc_pkg::PIX_W-1:0]        pixel_o
);

  localparam int unsigned DW = ACC_W + 1;
  localparam int unsigned CW = (DW > TALLY_W + 8) ? DW : TALLY_W + 8;
  localparam int unsigned SW = $clog2(bdsc_pkg::QUOT_STEPS);
  localparam int unsigned AW = bdsc_pkg::CH_W + 3;

  logic [CW-1:0]                rem_q [4];
  logic [CW-1:0]                rem_d [4];
  logic [bdsc_pkg::CH_W-1:0]    quo_q [4];
  logic [bdsc_pkg::CH_W-1:0]    quo_d [4];
  logic [TALLY_W-1:0]           n_q;
  logic [SW-1:0]                step_q;
  logic                         busy_q;
  logic [CW-1:0]                dsh;
  logic [CW-1:0]                half;
  logic [ACC_W-1:0]             sums [4];
  logic signed [AW-1:0]         alpha_s;
  logic [bdsc_pkg::CH_W-1:0]    alpha_c;

  assign sums[0] = sum_a_i;
  assign sums[1] = sum_r_i;
  assign sums[2] = sum_g_i;
  assign sums[3] = sum_b_i;
  assign half    = CW'(tally_i >> 1);
  assign dsh     = CW'(n_q) << step_q;

  // One trial subtraction per lane
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rem_d[c] = rem_q[c];
      quo_d[c] = quo_q[c];
      if (start_i) begin
        rem_d[c] = CW'(sums[c]) + half;
        quo_d[c] = '0;
      end else if (busy_q && rem_q[c] >= dsh) begin
        rem_d[c]         = rem_q[c] - dsh;
        quo_d[c][step_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      rem_q[c] <= rem_d[c];
      quo_q[c] <= quo_d[c];
    end
    if (start_i) begin
      n_q <= tally_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= SW'(bdsc_pkg::QUOT_STEPS - 1);
    end else if (busy_q) begin
      busy_q <= (step_q != '0);
      step_q <= step_q - 1'b1;
    end
  end

  // Alpha gets the brightness offset and a clamp to 0..255
  assign alpha_s = $signed({3'b000, quo_q[0]}) + AW'(badj_i);
  always_comb begin
    if (alpha_s < 0) begin
      alpha_c = '0;
    end else if (alpha_s > $signed(AW'(255))) begin
      alpha_c = '1;
    end else begin
      alpha_c = alpha_s[bdsc_pkg::CH_W-1:0];
    end
  end

  assign busy_o  = busy_q;
  assign pixel_o = (n_q == '0) ? '0 : {alpha_c, quo_q[1], quo_q[2], quo_q[3]};

endmodule

// ----- hdl/bdsc_checker.sv -----
// Port-level checks of the box downscaler, bound to the top level.
module bdsc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [bdsc_pkg::PIX_W-1:0]   pixel_out_o,
  input logic                         last_out_o
);

  // A stalled output word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pixel_out_o) && $stable(last_out_o))
    else $error("output payload changed while stalled");

  // One source word at a time: no accept right after an accept
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("source word taken while previous one in flight");

  // A register write forces a position fix-up before the next word
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=> !in_ready_o)
    else $error("source word taken straight after a register write");

  // A result cannot appear the cycle after a word is taken
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result appeared too soon after a source word");

endmodule

bind box_downscale_2d_alpha_weighted bdsc_checker u_bdsc_checker (.*);

// ----- tb/box_downscale_2d_alpha_weighted_tb.sv -----
// Self-checking testbench for the alpha-weighted ARGB box downscaler.
`timescale 1ns / 100ps

module box_downscale_2d_alpha_weighted_tb;

  localparam int unsigned ACC_DEPTH = bdsc_pkg::MAX_WIDTH_DEF / 2;
  localparam int unsigned SETTLE    = 64;   // divider re-derive plus mean unit

  typedef struct packed {
    logic [bdsc_pkg::PIX_W-1:0] pixel;
    logic                       last;
  } out_word_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bdsc_pkg::PADDR_W-1:0]   paddr = '0;
  logic [bdsc_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [bdsc_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [bdsc_pkg::PIX_W-1:0]     pixel_in_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [bdsc_pkg::PIX_W-1:0]     pixel_out_o;
  logic                           last_out_o;

  box_downscale_2d_alpha_weighted DUT (.*);

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor copy of the registers and the column accumulators
  logic [bdsc_pkg::SCALE_W-1:0] m_scale  = bdsc_pkg::SCALE_RST;
  logic [bdsc_pkg::SIZE_W-1:0]  m_width  = bdsc_pkg::WIDTH_RST;
  logic [bdsc_pkg::SIZE_W-1:0]  m_height = bdsc_pkg::HEIGHT_RST;
  int                           m_badj   = 0;
  logic                         m_aw     = 1'b0;
  int unsigned sum_a[ACC_DEPTH], sum_r[ACC_DEPTH], sum_g[ACC_DEPTH], sum_b[ACC_DEPTH];
  int unsigned tally[ACC_DEPTH];
  int unsigned pos_col = 0, pos_row = 0;

  out_word_t pending_px[$];
  int        fails = 0;
  int        words_sent = 0;
  int        words_got  = 0;
  int        cfg_writes = 0;
  bit        stall_req  = 1'b0;
  bit        burst      = 1'b0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Works out the downscaled word (if any) that one source word produces
  function automatic void predict_box(logic [bdsc_pkg::PIX_W-1:0] px);
    int unsigned sc, w, h, kx, ky, nw, nh, bx, by, ix, iy, slot, n, half;
    int unsigned ca, cr, cg, cb, cn;
    int av;
    out_word_t res;
    sc = clampu(m_scale, 2, bdsc_pkg::MAX_SCALE_DEF);
    w  = clampu(m_width, 1, bdsc_pkg::MAX_WIDTH_DEF);
    h  = clampu(m_height, 1, bdsc_pkg::HEIGHT_LIMIT);
    kx = (sc < w) ? sc : w;
    ky = (sc < h) ? sc : h;
    nw = w / kx;
    nh = h / ky;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    bx = pos_col / kx;  by = pos_row / ky;
    ix = pos_col % kx;  iy = pos_row % ky;
    if (bx < nw && by < nh) begin
      slot = bx % ACC_DEPTH;
      cn = (px[31:24] != 0 || !m_aw) ? 1 : 0;
      ca = cn ? px[31:24] : 0;
      cr = cn ? px[23:16] : 0;
      cg = cn ? px[15:8]  : 0;
      cb = cn ? px[7:0]   : 0;
      if (ix == 0 && iy == 0) begin
        sum_a[slot] = ca; sum_r[slot] = cr; sum_g[slot] = cg; sum_b[slot] = cb;
        tally[slot] = cn;
      end else begin
        sum_a[slot] += ca; sum_r[slot] += cr; sum_g[slot] += cg; sum_b[slot] += cb;
        tally[slot] += cn;
      end
      if (ix == kx - 1 && iy == ky - 1) begin
        n = tally[slot];
        res.pixel = '0;
        if (n != 0) begin
          half = n / 2;
          av = int'((sum_a[slot] + half) / n) + m_badj;
          av = (av < 0) ? 0 : (av > 255) ? 255 : av;
          res.pixel[31:24] = av[7:0];
          res.pixel[23:16] = 8'((sum_r[slot] + half) / n);
          res.pixel[15:8]  = 8'((sum_g[slot] + half) / n);
          res.pixel[7:0]   = 8'((sum_b[slot] + half) / n);
        end
        res.last = (bx == nw - 1 && by == nh - 1);
        pending_px.push_back(res);
      end
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_got++;
      if (pending_px.size() == 0) begin
        $error("unexpected word: pixel_out %h last_out %b", pixel_out_o, last_out_o);
        fails++;
      end else begin
        out_word_t exp_w;
        exp_w = pending_px.pop_front();
        if (pixel_out_o !== exp_w.pixel) begin
          $error("pixel_out: expected %h actual %h", exp_w.pixel, pixel_out_o);
          fails++;
        end
        if (last_out_o !== exp_w.last) begin
          $error("last_out: expected %b actual %b", exp_w.last, last_out_o);
          fails++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long counted hold-off on request
  initial begin
    int gap, held;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        out_ready_i <= 1'b0;
        for (held = 0; held < 400; held++) @(posedge clk_i);
        stall_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!burst && $urandom_range(99) < 25) begin
        gap = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Sends one source word; valid stays high if the next call follows with no gap
  task automatic send_word(logic [bdsc_pkg::PIX_W-1:0] px);
    int gap;
    gap = 0;
    if (!burst) begin
      case ($urandom_range(9))
        0:       gap = $urandom_range(30, 5);
        1, 2, 3: gap = $urandom_range(3, 1);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_box(px);
    words_sent++;
  endtask

  // Waits until every expected word is back and the block has gone quiet
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(bdsc_pkg::reg_idx_e idx, logic [bdsc_pkg::PDATA_W-1:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= bdsc_pkg::PADDR_W'({idx, 2'b00}); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bdsc_pkg::REG_SCALE:   m_scale  = val[bdsc_pkg::SCALE_W-1:0];
      bdsc_pkg::REG_WIDTH:   m_width  = val[bdsc_pkg::SIZE_W-1:0];
      bdsc_pkg::REG_HEIGHT:  m_height = val[bdsc_pkg::SIZE_W-1:0];
      bdsc_pkg::REG_BADJ:    m_badj   = int'($signed(val[bdsc_pkg::BADJ_W-1:0]));
      bdsc_pkg::REG_AWEIGHT: m_aw     = val[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic setup(int sc, int w, int h, int badj, bit aw);
    wait_idle();
    write_reg(bdsc_pkg::REG_SCALE, bdsc_pkg::PDATA_W'(sc));
    write_reg(bdsc_pkg::REG_WIDTH, bdsc_pkg::PDATA_W'(w));
    write_reg(bdsc_pkg::REG_HEIGHT, bdsc_pkg::PDATA_W'(h));
    write_reg(bdsc_pkg::REG_BADJ, bdsc_pkg::PDATA_W'(badj) & 32'h1ff);
    write_reg(bdsc_pkg::REG_AWEIGHT, bdsc_pkg::PDATA_W'(aw));
  endtask

  function automatic logic [bdsc_pkg::PIX_W-1:0] rand_px();
    logic [bdsc_pkg::PIX_W-1:0] px;
    px = $urandom;
    case ($urandom_range(7))
      0, 1: px[31:24] = 8'h00;
      2:    px[31:24] = 8'hff;
      default: ;
    endcase
    return px;
  endfunction

  // Sends random words until the raster position is back at the origin
  task automatic finish_image();
    do send_word(rand_px()); while (pos_col != 0 || pos_row != 0);
  endtask

  // Full-scale and zero words, rounding, and every register's first write
  task automatic test_extremes();
    setup(2, 4, 2, 0, 1'b0);
    send_word(32'hffff_ffff); send_word(32'h0000_0000);
    send_word(32'h0101_0101); send_word(32'hffff_ffff);
    send_word(32'h0000_0000); send_word(32'h0101_0101);
    send_word(32'h8040_20ff); send_word(32'h7f3f_1f00);
  endtask

  // Zero-alpha pixels skipped, and an all-transparent block gives zero
  task automatic test_alpha_weighting();
    setup(2, 4, 2, 255, 1'b1);
    send_word(32'h00ff_ffff); send_word(32'h00ff_ffff);
    send_word(32'h1011_2233); send_word(32'h00aa_bbcc);
    send_word(32'h00ff_ffff); send_word(32'h0012_3456);
    send_word(32'hff00_ff00); send_word(32'h00ff_00ff);
  endtask

  // Alpha clamps at both ends of the brightness range
  task automatic test_brightness();
    setup(2, 2, 2, -255, 1'b0);
    repeat (4) send_word(32'h80ff_0000);
    setup(2, 2, 2, 255, 1'b0);
    repeat (4) send_word(32'h80ff_0000);
  endtask

  // Scale below and above range, zero sizes, and width above the maximum
  task automatic test_range_clamps();
    setup(0, 5, 3, 0, 1'b0);
    finish_image();
    setup(31, 3, 20, 7, 1'b1);
    finish_image();
    setup(2, 0, 0, 0, 1'b0);
    finish_image();
    // part of an over-wide row, then a narrow width pushes the position off the image
    setup(16, 8191, 1, -3, 1'b1);
    repeat (40) send_word(rand_px());
    wait_idle();
    write_reg(bdsc_pkg::REG_WIDTH, 20);
    finish_image();
  endtask

  // Register writes mid-image leave the position outside the new bounds
  task automatic test_mid_image_change();
    setup(2, 4, 4, 0, 1'b0);
    repeat (7) send_word(rand_px());
    wait_idle();
    write_reg(bdsc_pkg::REG_WIDTH, 3);
    finish_image();
    setup(16, 1, 8191, 0, 1'b0);
    repeat (40) send_word(rand_px());
    wait_idle();
    write_reg(bdsc_pkg::REG_HEIGHT, 16);
    finish_image();
  endtask

  // Receiver holds off while words keep coming, so the input stalls
  task automatic test_backpressure();
    setup(2, 4, 4, 10, 1'b0);
    stall_req = 1'b1;
    burst = 1'b1;
    repeat (48) send_word(rand_px());
    burst = 1'b0;
  endtask

  // Random small images, each completed, a few with a pause part-way through
  task automatic test_random_images();
    int sc, w, h;
    while (words_sent < 400) begin
      sc = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(6, 2);
      w  = $urandom_range(12, 1);
      h  = $urandom_range(10, 1);
      setup(sc, w, h, $urandom_range(510) - 255, 1'($urandom_range(1)));
      burst = ($urandom_range(4) == 0);
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(w * h)) send_word(rand_px());
        wait_idle();
      end
      finish_image();
      burst = 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_alpha_weighting();
    test_brightness();
    test_range_clamps();
    test_mid_image_change();
    test_backpressure();
    test_random_images();
    wait_idle();
    $display("covered %0d source words, %0d downscaled words, %0d register writes",
             words_sent, words_got, cfg_writes);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bdsc_pkg.sv
hdl/bdsc_regs.sv
hdl/bdsc_acc_mem.sv
hdl/bdsc_mean.sv
hdl/box_downscale_2d_alpha_weighted.sv
hdl/bdsc_checker.sv
tb/box_downscale_2d_alpha_weighted_tb.sv
